/* src/kss_pkg.sv */
`default_nettype none
package kss_pkg;

	localparam int MAX_K    = 16;
	localparam int KEY_BITS = 32;
	localparam int TAG_BITS = 16;
	localparam int SEL_BITS = 5;
	localparam logic [SEL_BITS-1:0] SEL_RESET = SEL_BITS'(6);

	typedef struct packed {
		logic [KEY_BITS-1:0] key;
		logic [TAG_BITS-1:0] tag;
		logic                last_item;
	} kss_item_t;

	typedef struct packed {
		logic [KEY_BITS-1:0] out_key;
		logic [TAG_BITS-1:0] out_tag;
		logic                out_last;
	} kss_result_t;

	typedef struct packed {
		logic [KEY_BITS-1:0] key;
		logic [TAG_BITS-1:0] tag;
		logic                valid;
	} kss_entry_t;

	typedef struct packed {
		logic insert;
		logic shift;
		logic in_range;
	} kss_ctrl_t;

endpackage
`default_nettype wire

/* src/kss_cell.sv */
`default_nettype none
module kss_cell (
	input  wire                          clk,
	input  wire                          arst_n,
	input  kss_pkg::kss_ctrl_t           ctrl,
	input  wire [kss_pkg::KEY_BITS-1:0]  new_key,
	input  wire [kss_pkg::TAG_BITS-1:0]  new_tag,
	input  kss_pkg::kss_entry_t          prev_entry,
	input  wire                          prev_keep,
	input  kss_pkg::kss_entry_t          next_entry,
	output kss_pkg::kss_entry_t          entry,
	output logic                         keep
);
	import kss_pkg::*;

	logic [KEY_BITS-1:0] key_q;
	logic [TAG_BITS-1:0] tag_q;
	logic                valid_q;

	// entry stays put when it is in range and not above the new key
	assign keep = valid_q && ctrl.in_range && (key_q <= new_key);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.insert) begin
			if (keep) begin
				valid_q <= 1'b1;
			end else if (prev_keep) begin
				valid_q <= ctrl.in_range;
			end else begin
				valid_q <= prev_entry.valid && ctrl.in_range;
			end
		end else if (ctrl.shift) begin
			valid_q <= next_entry.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.insert && !keep) begin
			if (prev_keep) begin
				key_q <= new_key;
				tag_q <= new_tag;
			end else begin
				key_q <= prev_entry.key;
				tag_q <= prev_entry.tag;
			end
		end else if (ctrl.shift) begin
			key_q <= next_entry.key;
			tag_q <= next_entry.tag;
		end
	end

	assign entry = '{key: key_q, tag: tag_q, valid: valid_q};

endmodule
`default_nettype wire

/* src/k_smallest_select.sv */
// The first result of a set is offered in the cycle after its last item transfers.
// Throughput: one item per cycle while a set loads; every cell compares in parallel.
// Output: min(n,k) results, one per cycle unless stalled, shifted out of the cell chain;
//   the item channel stalls from the last item until the final result transfers.
// Reset (arst_n low, asynchronous): all cells empty, no output pending, select_count = 6.
`default_nettype none
module k_smallest_select (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 select_count_we,
	input  wire [kss_pkg::SEL_BITS-1:0]         select_count_wdata,
	input  wire                                 item_valid,
	output logic                                item_stall,
	input  kss_pkg::kss_item_t                  item,
	output logic                                result_valid,
	input  wire                                 result_stall,
	output kss_pkg::kss_result_t                result
);
	import kss_pkg::*;

	logic [SEL_BITS-1:0] select_count_q;
	logic                drain_q;

	logic       item_xfer;
	logic       result_xfer;

	kss_entry_t ent  [MAX_K];
	kss_entry_t prv  [MAX_K];
	kss_entry_t nxt  [MAX_K];
	logic       keep [MAX_K];
	logic       pkeep[MAX_K];
	kss_ctrl_t  ctrl [MAX_K];

	// k register; a write of zero acts as one, anything past the chain length fills it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			select_count_q <= SEL_RESET;
		end else if (select_count_we) begin
			select_count_q <= select_count_wdata;
		end
	end

	// hold off new items while the sorted list drains
	assign item_stall  = drain_q;
	assign item_xfer   = item_valid && !item_stall;
	assign result_xfer = result_valid && !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drain_q <= 1'b0;
		end else if (item_xfer && item.last_item) begin
			drain_q <= 1'b1;
		end else if (result_xfer && result.out_last) begin
			drain_q <= 1'b0;
		end
	end

	// Chain: cell 0 holds the smallest key. On insert each cell keeps, takes the new
	// item, or takes its neighbor nearer cell 0; on drain every cell advances toward cell 0.
	genvar i;
	generate
		for (i = 0; i < MAX_K; i++) begin : g_cell
			if (i == 0) begin : g_head
				assign prv[i]   = '0;
				assign pkeep[i] = 1'b1;
			end else begin : g_body
				assign prv[i]   = ent[i-1];
				assign pkeep[i] = keep[i-1];
			end
			if (i == MAX_K - 1) begin : g_tail
				assign nxt[i] = '0;
			end else begin : g_mid
				assign nxt[i] = ent[i+1];
			end

			// cells at or past k drop out at the next insert, which trims a lowered k
			assign ctrl[i] = '{
				insert:   item_xfer,
				shift:    result_xfer,
				in_range: (i == 0) || (32'(i) < 32'(select_count_q))
			};

			kss_cell u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctrl       (ctrl[i]),
				.new_key    (item.key),
				.new_tag    (item.tag),
				.prev_entry (prv[i]),
				.prev_keep  (pkeep[i]),
				.next_entry (nxt[i]),
				.entry      (ent[i]),
				.keep       (keep[i])
			);
		end
	endgenerate

	// head cell is the output register; the final result is the one with no successor
	assign result_valid = drain_q && ent[0].valid;
	assign result       = '{out_key: ent[0].key, out_tag: ent[0].tag, out_last: !nxt[0].valid};

endmodule
`default_nettype wire

/* src/kss_checker.sv */
`default_nettype none
module kss_checker (
	input wire                    clk,
	input wire                    arst_n,
	input wire                    item_valid,
	input wire                    item_stall,
	input kss_pkg::kss_item_t     item,
	input wire                    result_valid,
	input wire                    result_stall,
	input kss_pkg::kss_result_t   result
);
	import kss_pkg::*;

	// no item is taken while results are pending
	a_stall_while_drain: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> item_stall)
		else $error("item channel open while results pending");

	// the last item of a set always yields a result next cycle
	a_result_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && !item_stall && item.last_item) |=> result_valid)
		else $error("no result after last item");

	// the final result closes the set
	a_quiet_after_final: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result_stall && result.out_last) |=> !result_valid)
		else $error("result after final transfer");

	// a stalled result holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_stall) |=> (result_valid && $stable(result)))
		else $error("stalled result changed");

endmodule

bind k_smallest_select kss_checker u_kss_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.item         (item),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);
`default_nettype wire

/* verif/testbench.sv */
`timescale 1ns / 100ps
module testbench;
	import kss_pkg::*;

	// Generous bound on the whole run.
	localparam int CYCLE_LIMIT = 200000;
	// Bound on the final wait for outstanding results.
	localparam int DRAIN_LIMIT = 20000;
	// Quiet cycles after the last result before a register write or the end.
	localparam int SETTLE_CYCLES = 4;
	localparam logic [KEY_BITS-1:0] KEY_MAX = '1;
	localparam logic [TAG_BITS-1:0] TAG_MAX = '1;

	typedef enum int {KEYS_WIDE, KEYS_CLUSTERED, KEYS_EDGES} key_spread_t;

	logic                clk;
	logic                arst_n = 1'b0;
	logic                select_count_we = 1'b0;
	logic [SEL_BITS-1:0] select_count_wdata = '0;
	logic                item_valid = 1'b0;
	logic                item_stall;
	kss_item_t           item = '0;
	logic                result_valid;
	logic                result_stall = 1'b0;
	kss_result_t         result;

	// Idle percentages for the current phase.
	int gap_pct = 0;
	int stall_pct = 0;

	int mismatches = 0;
	int cycle_count = 0;

	// Predicted block state: the sorted list of kept keys and the k register.
	logic [KEY_BITS-1:0] held_keys [MAX_K];
	logic [TAG_BITS-1:0] held_tags [MAX_K];
	int                  held_count = 0;
	logic [SEL_BITS-1:0] k_setting = SEL_RESET;

	// Expected results, oldest first.
	kss_result_t pending_results [$];

	k_smallest_select DUT (
		.clk                (clk),
		.arst_n             (arst_n),
		.select_count_we    (select_count_we),
		.select_count_wdata (select_count_wdata),
		.item_valid         (item_valid),
		.item_stall         (item_stall),
		.item               (item),
		.result_valid       (result_valid),
		.result_stall       (result_stall),
		.result             (result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Abort a hung run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, pending_results.size());
			$display("k_smallest_select regression: fail");
			$finish;
		end
	end

	task automatic report_mismatch(input string what);
		mismatches++;
		$display("MISMATCH at %0t: %s", $time, what);
	endtask

	// Fold one accepted item into the predicted list; on the last item of a set,
	// queue the kept keys in ascending order and empty the list.
	task automatic absorb_item(input kss_item_t it);
		int lim;
		int n;
		int pos;
		int top;
		int i;
		kss_result_t r;
		lim = (k_setting == 0) ? 1 : ((int'(k_setting) > MAX_K) ? MAX_K : int'(k_setting));
		// A lowered k cuts the list here, keeping the smallest entries.
		if (held_count > lim)
			held_count = lim;
		n = held_count;
		// Insert after every key that is less or equal, so ties keep arrival order.
		pos = 0;
		while (pos < n && held_keys[pos] <= it.key)
			pos++;
		if (pos < lim) begin
			top = (n < lim) ? n : lim - 1;
			for (i = top; i > pos; i--) begin
				held_keys[i] = held_keys[i-1];
				held_tags[i] = held_tags[i-1];
			end
			held_keys[pos] = it.key;
			held_tags[pos] = it.tag;
			if (n < lim)
				held_count = n + 1;
		end
		if (it.last_item) begin
			for (i = 0; i < held_count; i++) begin
				r.out_key  = held_keys[i];
				r.out_tag  = held_tags[i];
				r.out_last = (i == held_count - 1);
				pending_results.push_back(r);
			end
			held_count = 0;
		end
	endtask

	// Drive one item at a falling edge, hold it until the transfer, then predict.
	// Valid stays high after the transfer; the next call or release_items moves it.
	task automatic send_item(input kss_item_t it);
		@(negedge clk);
		while ($urandom_range(99) < gap_pct) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		do
			@(posedge clk);
		while (item_stall);
		absorb_item(it);
	endtask

	task automatic release_items();
		@(negedge clk);
		item_valid <= 1'b0;
	endtask

	// Wait until every expected result has arrived, then let the pipeline drain.
	task automatic settle();
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write k; the caller has dropped item valid and settled the block.
	task automatic write_select_count(input logic [SEL_BITS-1:0] value);
		@(negedge clk);
		select_count_we <= 1'b1;
		select_count_wdata <= value;
		@(negedge clk);
		select_count_we <= 1'b0;
		k_setting = value;
	endtask

	function automatic kss_item_t make_item(input logic [KEY_BITS-1:0] key,
			input logic [TAG_BITS-1:0] tag, input logic last_item);
		kss_item_t it;
		it.key = key;
		it.tag = tag;
		it.last_item = last_item;
		return it;
	endfunction

	function automatic logic [KEY_BITS-1:0] random_key(input key_spread_t spread);
		case (spread)
			KEYS_CLUSTERED: return KEY_BITS'($urandom_range(7));
			KEYS_EDGES: begin
				case ($urandom_range(3))
					0: return '0;
					1: return KEY_MAX;
					2: return KEY_MAX - 1;
					default: return KEY_BITS'(1);
				endcase
			end
			default: return KEY_BITS'($urandom);
		endcase
	endfunction

	// Favor the corners of k: zero, one, sixteen, and values past the saturation point.
	function automatic logic [SEL_BITS-1:0] random_select();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			2: return SEL_BITS'(1);
			3: return SEL_BITS'(MAX_K);
			4: return SEL_BITS'($urandom_range(17, 30));
			default: return SEL_BITS'($urandom_range(2, 15));
		endcase
	endfunction

	// Reset value of k: more items than kept, extreme keys and tags, equal keys.
	task automatic test_reset_setting();
		send_item(make_item(KEY_BITS'(5), TAG_BITS'(1), 1'b0));
		send_item(make_item('0, '0, 1'b0));
		send_item(make_item(KEY_MAX, TAG_MAX, 1'b0));
		send_item(make_item(KEY_BITS'(5), TAG_BITS'(2), 1'b0));
		send_item(make_item(KEY_BITS'(3), TAG_BITS'(3), 1'b0));
		send_item(make_item(KEY_MAX, TAG_BITS'(4), 1'b0));
		send_item(make_item(KEY_BITS'(1), TAG_BITS'(5), 1'b0));
		send_item(make_item(KEY_BITS'(5), TAG_BITS'(6), 1'b1));
		release_items();
		settle();
	endtask

	// A set of one item still yields one result, marked final.
	task automatic test_single_item();
		send_item(make_item(KEY_BITS'($urandom), TAG_BITS'($urandom), 1'b1));
		release_items();
		settle();
	endtask

	// k of zero behaves as one; the earlier of two equal keys wins.
	task automatic test_select_floor();
		write_select_count('0);
		send_item(make_item(KEY_BITS'(9), TAG_BITS'(10), 1'b0));
		send_item(make_item(KEY_BITS'(2), TAG_BITS'(11), 1'b0));
		send_item(make_item(KEY_BITS'(2), TAG_BITS'(12), 1'b1));
		release_items();
		settle();
	endtask

	// k above the cell count saturates; fewer items than k emits them all.
	task automatic test_select_ceiling();
		int i;
		write_select_count('1);
		for (i = 0; i < 6; i++)
			send_item(make_item(KEY_BITS'($urandom), TAG_BITS'(i), i == 5));
		release_items();
		settle();
	endtask

	// Lower k in the middle of a set; the list is cut at the next item.
	task automatic test_select_lowered();
		write_select_count(SEL_BITS'(5));
		send_item(make_item(KEY_BITS'(40), TAG_BITS'(20), 1'b0));
		send_item(make_item(KEY_BITS'(10), TAG_BITS'(21), 1'b0));
		send_item(make_item(KEY_BITS'(30), TAG_BITS'(22), 1'b0));
		send_item(make_item(KEY_BITS'(20), TAG_BITS'(23), 1'b0));
		release_items();
		settle();
		write_select_count(SEL_BITS'(2));
		send_item(make_item(KEY_BITS'(15), TAG_BITS'(24), 1'b1));
		release_items();
		settle();
	endtask

	// Random sets under one idling pattern: now and then a random k between sets or
	// a k change in mid set, keys spread wide, clustered for ties, or at the edges.
	task automatic test_random_sets(input int sender_gap, input int receiver_stall,
			input int item_goal);
		int sent;
		int len;
		int cut_at;
		int j;
		key_spread_t spread;
		gap_pct = sender_gap;
		stall_pct = receiver_stall;
		sent = 0;
		while (sent < item_goal) begin
			if ($urandom_range(2) == 0) begin
				settle();
				write_select_count(random_select());
			end
			len = ($urandom_range(7) == 0) ? $urandom_range(17, 24) : $urandom_range(1, 16);
			spread = key_spread_t'($urandom_range(2));
			cut_at = ($urandom_range(7) == 0 && len > 2) ? $urandom_range(1, len - 1) : -1;
			for (j = 0; j < len; j++) begin
				if (j == cut_at) begin
					release_items();
					settle();
					write_select_count(random_select());
				end
				send_item(make_item(random_key(spread), TAG_BITS'($urandom), j == len - 1));
			end
			release_items();
			sent += len;
		end
		settle();
	endtask

	// Receiver stalls at random, at the current phase's rate.
	always @(negedge clk)
		result_stall <= ($urandom_range(99) < stall_pct);

	// Compare each result transfer with the oldest expectation.
	always @(posedge clk) begin : result_check
		kss_result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("unexpected result key=%h tag=%h last=%b",
					result.out_key, result.out_tag, result.out_last));
			end else begin
				want = pending_results.pop_front();
				if (result.out_key !== want.out_key || result.out_tag !== want.out_tag ||
						result.out_last !== want.out_last)
					report_mismatch($sformatf(
						"key=%h tag=%h last=%b, expected key=%h tag=%h last=%b",
						result.out_key, result.out_tag, result.out_last,
						want.out_key, want.out_tag, want.out_last));
			end
		end
	end

	initial begin : run
		int waited;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part, no idling.
		test_reset_setting();
		test_single_item();
		test_select_floor();
		test_select_ceiling();
		test_select_lowered();

		// Random part: no idling, sender idle, receiver stalling, both.
		test_random_sets(0, 0, 66);
		test_random_sets(64, 0, 66);
		test_random_sets(0, 64, 66);
		test_random_sets(31, 31, 66);

		// Drain what is left, bounded, then give stray results a chance to show.
		gap_pct = 0;
		stall_pct = 0;
		for (waited = 0; waited < DRAIN_LIMIT && pending_results.size() != 0; waited++)
			@(posedge clk);
		repeat (SETTLE_CYCLES * 4) @(posedge clk);
		if (pending_results.size() != 0)
			report_mismatch($sformatf("%0d expected results never arrived",
				pending_results.size()));

		if (mismatches == 0)
			$display("k_smallest_select regression: pass");
		else
			$display("k_smallest_select regression: fail");
		$finish;
	end

endmodule
